// ----- sv/ape_pkg.sv -----
// Shared types, constants and helpers for the audio peak envelope block.
// Used by the channel interfaces and every module of the block but ape_ram.
package ape_pkg;

    // Store and field geometry
    localparam int MAX_BUCKETS = 64;
    localparam int BIDX_W      = $clog2(MAX_BUCKETS);
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 15;
    localparam int BCNT_W      = 7;
    localparam int CCNT_W      = 8;
    localparam int FCNT_W      = 31;
    localparam int PROD_W      = FCNT_W + BCNT_W;
    localparam int DCNT_W      = $clog2(BIDX_W);

    localparam logic [LEVEL_W-1:0] FULL_SCALE = '1;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_BUCKET_COUNT  = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT   = 2'd2;

    localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST  = BCNT_W'(MAX_BUCKETS);
    localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RST = CCNT_W'(1);
    localparam logic [FCNT_W-1:0] FRAME_COUNT_RST   = FCNT_W'(1);

    // One unit of work for the back part
    typedef struct packed {
        logic                do_frame;
        logic                do_flush;
        logic [FCNT_W-1:0]   frame_idx;
        logic [LEVEL_W-1:0]  peak;
    } t_job;

    // Bucket count with values above the store size clamped to the store size
    function automatic logic [BCNT_W-1:0] active_buckets(input logic [BCNT_W-1:0] bc);
        active_buckets = (bc > BCNT_W'(MAX_BUCKETS)) ? BCNT_W'(MAX_BUCKETS) : bc;
    endfunction

endpackage

// ----- sv/ape_if.sv -----
// Valid/ready channel interfaces for samples in and bucket peaks out.
// Depends on ape_pkg for field widths.
interface ape_in_if import ape_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       final_req;

    modport source (output valid, output sample, output final_req, input ready);
    modport sink   (input valid, input sample, input final_req, output ready);
endinterface

interface ape_out_if import ape_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BIDX_W-1:0]  bucket_index;
    logic [LEVEL_W-1:0] peak_level;
    logic               last;

    modport source (output valid, output bucket_index, output peak_level, output last,
                    input ready);
    modport sink   (input valid, input bucket_index, input peak_level, input last,
                    output ready);
endinterface

// ----- sv/audio_peak_envelope_top.sv -----
// Audio peak envelope, top level.
// Channels: i_in carries one signed 16-bit sample per item plus final_req;
// o_out carries one bucket peak per item (bucket_index, peak_level, last).
// Configuration: APB-style writes of bucket_count (0x0), channel_count (0x4)
// and frame_count (0x8); write only while the block is idle.
// Flow: a sample is accepted whenever the job queue has room. Each
// completed frame takes the bucket engine through a queue pop, one 31x7
// multiply, six divide steps, a RAM read and a RAM write, and the engine
// takes no new job until it is through; samples of a frame that do not
// complete it cost the engine nothing. On final_req the engine sweeps the
// bucket RAM, a read and an output per bucket, and emits one item per
// active bucket (bucket_count capped at 64), then clears the store.
// Reset: synchronous, active low; registers return to 64 / 1 / 1 and all
// buckets read as zero at once (valid bits), no clearing pass.
// Stall: results wait in the output register; the engine and then the
// queue fill up, and i_in.ready drops once the four-entry queue is full.
module audio_peak_envelope_top import ape_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ape_in_if.sink            i_in,
    ape_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    logic [BCNT_W-1:0] r_bucket_count;
    logic [CCNT_W-1:0] r_channel_count;
    logic [FCNT_W-1:0] r_frame_count;
    logic [BCNT_W-1:0] w_nb;
    logic [1:0]        w_reg_idx;
    logic              w_wr;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_push_job;
    t_job w_pop_job;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;
    assign w_nb      = active_buckets(r_bucket_count);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count  <= BUCKET_COUNT_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
            r_frame_count   <= FRAME_COUNT_RST;
        end else if (w_wr && (paddr[1:0] == 2'b00)) begin
            unique case (w_reg_idx)
                REG_BUCKET_COUNT:  r_bucket_count  <= pwdata[BCNT_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[CCNT_W-1:0];
                REG_FRAME_COUNT:   r_frame_count   <= pwdata[FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (w_reg_idx)
            REG_BUCKET_COUNT:  prdata = DATA_W'(r_bucket_count);
            REG_CHANNEL_COUNT: prdata = DATA_W'(r_channel_count);
            REG_FRAME_COUNT:   prdata = DATA_W'(r_frame_count);
            default:           prdata = '0;
        endcase
    end

    ape_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_nb            (w_nb),
        .i_channel_count (r_channel_count),
        .i_frame_count   (r_frame_count),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    ape_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_pop_job  (w_pop_job),
        .o_empty    (w_empty)
    );

    ape_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nb          (w_nb),
        .i_frame_count (r_frame_count),
        .i_empty       (w_empty),
        .i_job         (w_pop_job),
        .o_pop         (w_pop),
        .o_out         (o_out)
    );
endmodule

// ----- sv/ape_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ape_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/ape_queue.sv -----
// Short job FIFO that decouples the sample front end from the bucket engine.
// Depends on ape_pkg for t_job and the queue depth.
module ape_queue import ape_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_job,
    output logic o_empty
);
    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full    = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_job = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("job popped from empty queue");
endmodule

// ----- sv/ape_front.sv -----
// Sample front end: magnitude, frame peak, frame counting and job issue.
// Depends on ape_pkg and the ape_in_if channel.
module ape_front import ape_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ape_in_if.sink            i_in,
    input  logic [BCNT_W-1:0] i_nb,
    input  logic [CCNT_W-1:0] i_channel_count,
    input  logic [FCNT_W-1:0] i_frame_count,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job
);
    logic [LEVEL_W-1:0] r_frame_peak;
    logic [CCNT_W-1:0]  r_chpos;
    logic [FCNT_W-1:0]  r_fidx;

    logic [SAMPLE_W-1:0] w_abs;
    logic [LEVEL_W-1:0]  w_mag;
    logic [LEVEL_W-1:0]  w_peak;
    logic [CCNT_W-1:0]   w_chans;
    logic                w_close;
    logic                w_take;
    logic                w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    // Magnitude, saturating the most negative code to full scale
    assign w_abs = i_in.sample[SAMPLE_W-1] ? SAMPLE_W'(-i_in.sample)
                                           : SAMPLE_W'(i_in.sample);
    assign w_mag = (w_abs > SAMPLE_W'(FULL_SCALE)) ? FULL_SCALE : w_abs[LEVEL_W-1:0];
    assign w_peak = (w_mag > r_frame_peak) ? w_mag : r_frame_peak;

    // Frame closes once the channel position reaches the channel count
    assign w_chans = (i_channel_count == '0) ? CCNT_W'(1) : i_channel_count;
    assign w_close = (({1'b0, r_chpos} + (CCNT_W+1)'(1)) >= {1'b0, w_chans});
    assign w_take  = w_close && (r_fidx < i_frame_count);

    // Build the job for the back part
    always_comb begin
        o_job.do_frame  = w_take && (i_nb != '0);
        o_job.do_flush  = i_in.final_req;
        o_job.frame_idx = r_fidx;
        o_job.peak      = w_peak;
    end
    assign o_push = w_accept && (o_job.do_frame || o_job.do_flush);

    // Track frame state; drop everything after the final sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_peak <= '0;
            r_chpos      <= '0;
            r_fidx       <= '0;
        end else if (w_accept) begin
            priority if (i_in.final_req) begin
                r_frame_peak <= '0;
                r_chpos      <= '0;
                r_fidx       <= '0;
            end else if (w_close) begin
                r_frame_peak <= '0;
                r_chpos      <= '0;
                if (w_take) begin
                    r_fidx <= r_fidx + 1'b1;
                end
            end else begin
                r_frame_peak <= w_peak;
                r_chpos      <= r_chpos + 1'b1;
            end
        end
    end
endmodule

// ----- sv/ape_back.sv -----
// Bucket engine: bucket index by multiply and iterative divide, peak update
// in the bucket RAM, and the emission sweep. Depends on ape_pkg, ape_ram, ape_out_if.
module ape_back import ape_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BCNT_W-1:0] i_nb,
    input  logic [FCNT_W-1:0] i_frame_count,
    input  logic              i_empty,
    input  t_job              i_job,
    output logic              o_pop,
    ape_out_if.source         o_out
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_FRD  = 3'd5;
    localparam logic [2:0] S_FOUT = 3'd6;

    logic [2:0]           r_state;
    logic [MAX_BUCKETS-1:0] r_valid;
    logic                 r_out_valid;
    t_job                 r_job;
    logic [FCNT_W-1:0]    r_rem;
    logic [BIDX_W-1:0]    r_nlo;
    logic [BIDX_W-1:0]    r_q;
    logic [DCNT_W-1:0]    r_cnt;
    logic [BIDX_W-1:0]    r_k;
    logic [BIDX_W-1:0]    r_out_idx;
    logic [LEVEL_W-1:0]   r_out_peak;
    logic                 r_out_last;

    logic [PROD_W-1:0]    w_prod;
    logic [FCNT_W:0]      w_trial;
    logic [FCNT_W:0]      w_diff;
    logic                 w_ge;
    logic [LEVEL_W-1:0]   w_rdata;
    logic [LEVEL_W-1:0]   w_old;
    logic                 w_re;
    logic [BIDX_W-1:0]    w_raddr;
    logic                 w_we;
    logic                 w_out_free;
    logic                 w_k_last;

    // Bucket numerator and one restoring-division step
    assign w_prod  = PROD_W'(r_job.frame_idx) * PROD_W'(i_nb);
    assign w_trial = {r_rem, r_nlo[BIDX_W-1]};
    assign w_diff  = w_trial - {1'b0, i_frame_count};
    assign w_ge    = (w_trial >= {1'b0, i_frame_count});

    // Bucket store access; an unwritten bucket reads as zero
    assign w_old   = r_valid[r_q] ? w_rdata : '0;
    assign w_re    = (r_state == S_RD) || (r_state == S_FRD);
    assign w_raddr = (r_state == S_FRD) ? r_k : r_q;
    assign w_we    = (r_state == S_WR) && (r_job.peak > w_old);

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_k_last   = (({1'b0, r_k} + BCNT_W'(1)) == i_nb);

    ape_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_q),
        .i_wdata (r_job.peak),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequence jobs and bucket valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        priority if (i_job.do_frame) begin
                            r_state <= S_MUL;
                        end else if (i_job.do_flush && (i_nb != '0)) begin
                            r_state <= S_FRD;
                        end else if (i_job.do_flush) begin
                            r_valid <= '0;
                        end
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    if (w_we) begin
                        r_valid[r_q] <= 1'b1;
                    end
                    r_state <= r_job.do_flush ? S_FRD : S_IDLE;
                end
                S_FRD: r_state <= S_FOUT;
                S_FOUT: begin
                    if (w_out_free) begin
                        if (w_k_last) begin
                            r_valid <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_FRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Load the output register from the sweep; drop valid once the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FOUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_k   <= '0;
            end
            S_MUL: begin
                r_rem <= w_prod[FCNT_W+BIDX_W-1:BIDX_W];
                r_nlo <= w_prod[BIDX_W-1:0];
                r_cnt <= DCNT_W'(BIDX_W - 1);
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[FCNT_W-1:0] : w_trial[FCNT_W-1:0];
                r_nlo <= r_nlo << 1;
                r_q   <= {r_q[BIDX_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_FOUT: begin
                if (w_out_free) begin
                    r_out_idx  <= r_k;
                    r_out_peak <= r_valid[r_k] ? w_rdata : '0;
                    r_out_last <= w_k_last;
                    r_k        <= r_k + 1'b1;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.bucket_index = r_out_idx;
    assign o_out.peak_level   = r_out_peak;
    assign o_out.last         = r_out_last;

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> ({1'b0, r_out_idx} + BCNT_W'(1) == i_nb))
        else $error("last flag not on final bucket");
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ({1'b0, r_q} < i_nb))
        else $error("bucket index out of range");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < i_frame_count))
        else $error("divider remainder not below divisor");
endmodule

// ----- tb/sv/tb_audio_peak_envelope_top.sv -----
`timescale 1ns / 1ps
// Testbench for audio_peak_envelope_top: a directed table, then random runs of frames
// closed by final_req, each bucket peak checked against an in-bench envelope predictor or a table value.
// Depends on ape_pkg, the ape_in_if / ape_out_if channels and the block's RTL.
module tb_audio_peak_envelope_top;
    import ape_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEM_TARGET   = 420;
    localparam int QUIET_FROM    = 360;

    typedef struct {
        logic [BIDX_W-1:0]  bucket_index;
        logic [LEVEL_W-1:0] peak_level;
        logic               last;
    } t_peak_result;

    typedef struct {
        bit                         is_cfg;
        logic [1:0]                 reg_idx;
        logic [DATA_W-1:0]          value;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         fin;
        bit                         typed;
        logic [LEVEL_W-1:0]         typed_peak;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ape_in_if  in_ch ();
    ape_out_if out_ch ();

    audio_peak_envelope_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the settings and the envelope store
    logic [BCNT_W-1:0]  bucket_cfg;
    logic [CCNT_W-1:0]  chan_cfg;
    logic [FCNT_W-1:0]  frame_cfg;
    logic [LEVEL_W-1:0] frame_max;
    logic [CCNT_W-1:0]  chan_pos;
    logic [FCNT_W-1:0]  frames_seen;
    logic [LEVEL_W-1:0] bucket_peak [MAX_BUCKETS];

    t_peak_result bucket_peak_q [$];
    t_stim_row    stim_table [$];
    string        reg_name [3] = '{"bucket_count", "channel_count", "frame_count"};

    int err_count   = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_flushes   = 0;
    int n_cfg       = 0;
    int n_in_stalls = 0;
    int gap_pct     = 0;
    bit hold_req    = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous run limit
    initial begin
        #(50_000_000);
        $display("tb_audio_peak_envelope_top: done, errors");
        $finish;
    end

    // Empty the store and restart frame counting
    function automatic void envelope_clear();
        frame_max   = '0;
        chan_pos    = '0;
        frames_seen = '0;
        foreach (bucket_peak[k]) bucket_peak[k] = '0;
    endfunction

    // Update the settings copy; return the value a readback should show
    function automatic logic [DATA_W-1:0] envelope_config(input logic [1:0] idx,
                                                          input logic [DATA_W-1:0] val);
        case (idx)
            REG_BUCKET_COUNT: begin
                bucket_cfg = val[BCNT_W-1:0];
                return DATA_W'(val[BCNT_W-1:0]);
            end
            REG_CHANNEL_COUNT: begin
                chan_cfg = val[CCNT_W-1:0];
                return DATA_W'(val[CCNT_W-1:0]);
            end
            REG_FRAME_COUNT: begin
                frame_cfg = val[FCNT_W-1:0];
                return DATA_W'(val[FCNT_W-1:0]);
            end
            default: return '0;
        endcase
    endfunction

    // Take one sample; on final_req queue every bucket peak (when keep is set)
    function automatic void envelope_take(input logic signed [SAMPLE_W-1:0] smp,
                                          input bit fin, input bit keep);
        logic [SAMPLE_W-1:0] raw;
        logic [SAMPLE_W-1:0] mag;
        int unsigned         nb;
        int unsigned         chans;
        longint unsigned     slot;
        t_peak_result        r;
        raw = smp;
        mag = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
        if (mag > {1'b0, FULL_SCALE}) mag = {1'b0, FULL_SCALE};
        nb    = (bucket_cfg > BCNT_W'(MAX_BUCKETS)) ? MAX_BUCKETS : bucket_cfg;
        chans = (chan_cfg == '0) ? 1 : chan_cfg;
        if (mag[LEVEL_W-1:0] > frame_max) frame_max = mag[LEVEL_W-1:0];

        // Close the frame once its last channel is in; frames past the end only reset
        if (int'(chan_pos) + 1 >= chans) begin
            if (frames_seen < frame_cfg) begin
                if (nb > 0) begin
                    slot = (64'(frames_seen) * 64'(nb)) / 64'(frame_cfg);
                    if (slot > nb - 1) slot = nb - 1;
                    if (frame_max > bucket_peak[slot]) bucket_peak[slot] = frame_max;
                end
                frames_seen = frames_seen + 1'b1;
            end
            frame_max = '0;
            chan_pos  = '0;
        end else begin
            chan_pos = chan_pos + 1'b1;
        end

        // Emit buckets in order, drop any partial frame and clear
        if (fin) begin
            if (keep) begin
                for (int k = 0; k < nb; k++) begin
                    r.bucket_index = BIDX_W'(k);
                    r.peak_level   = bucket_peak[k];
                    r.last         = (k + 1 == nb);
                    bucket_peak_q.push_back(r);
                end
            end
            envelope_clear();
        end
    endfunction

    function automatic void row_cfg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        t_stim_row r;
        r.is_cfg     = 1'b1;
        r.reg_idx    = idx;
        r.value      = val;
        r.smp        = '0;
        r.fin        = 1'b0;
        r.typed      = 1'b0;
        r.typed_peak = '0;
        stim_table.push_back(r);
    endfunction

    function automatic void row_smp(input logic signed [SAMPLE_W-1:0] s, input bit fin,
                                    input bit typed, input logic [LEVEL_W-1:0] pk);
        t_stim_row r;
        r.is_cfg     = 1'b0;
        r.reg_idx    = '0;
        r.value      = '0;
        r.smp        = s;
        r.fin        = fin;
        r.typed      = typed;
        r.typed_peak = pk;
        stim_table.push_back(r);
    endfunction

    // Offer one sample item, hold it until taken, then advance the predictor
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input bit fin,
                               input bit typed, input logic [LEVEL_W-1:0] pk);
        t_peak_result r;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= smp;
        in_ch.final_req <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            n_in_stalls++;
            @(posedge i_clk);
        end
        envelope_take(smp, fin, !typed);
        if (typed) begin
            r.bucket_index = '0;
            r.peak_level   = pk;
            r.last         = 1'b1;
            bucket_peak_q.push_back(r);
        end
        n_items++;
        if (fin) n_flushes++;
    endtask

    // Drop valid, wait for all results, then let the engine drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (bucket_peak_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then read it back
    task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = envelope_config(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== want) begin
            err_count++;
            $error("%s readback: expected %0h, got %0h", reg_name[idx], want, rd);
        end
        n_cfg++;
        @(posedge i_clk);
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each taken result with the oldest expected bucket peak
    always @(posedge i_clk) begin
        t_peak_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (bucket_peak_q.size() == 0) begin
                err_count++;
                $error("unexpected item: bucket_index %0d, peak_level %0d, last %0b",
                       out_ch.bucket_index, out_ch.peak_level, out_ch.last);
            end else begin
                e = bucket_peak_q.pop_front();
                if (out_ch.bucket_index !== e.bucket_index) begin
                    err_count++;
                    $error("bucket_index: expected %0d, got %0d",
                           e.bucket_index, out_ch.bucket_index);
                end
                if (out_ch.peak_level !== e.peak_level) begin
                    err_count++;
                    $error("peak_level: expected %0d, got %0d",
                           e.peak_level, out_ch.peak_level);
                end
                if (out_ch.last !== e.last) begin
                    err_count++;
                    $error("last: expected %0b, got %0b", e.last, out_ch.last);
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_stim_row                  row;
        logic [DATA_W-1:0]          bc;
        logic [DATA_W-1:0]          cc;
        logic [DATA_W-1:0]          fc;
        logic signed [SAMPLE_W-1:0] s;
        int                         ce;
        int                         runs;
        int                         nfr;
        int                         total;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample    <= '0;
        in_ch.final_req <= 1'b0;
        bucket_cfg = BUCKET_COUNT_RST;
        chan_cfg   = CHANNEL_COUNT_RST;
        frame_cfg  = FRAME_COUNT_RST;
        envelope_clear();

        // Reset settings: one counted frame, then a frame past the end, then the final
        row_smp(16'sd1234, 1'b0, 1'b0, '0);
        row_smp(16'sh8000, 1'b0, 1'b0, '0);
        row_smp(16'sd100, 1'b1, 1'b0, '0);
        // One bucket: extremes of the sample, each read off directly
        row_cfg(REG_BUCKET_COUNT, 32'd1);
        row_smp(16'sh8000, 1'b1, 1'b1, 15'd32767);
        row_smp(16'sh7FFF, 1'b1, 1'b1, 15'd32767);
        row_smp(16'shFFFF, 1'b1, 1'b1, 15'd1);
        row_smp(16'sd0, 1'b1, 1'b1, 15'd0);
        // Zero frame_count ignores every frame
        row_cfg(REG_FRAME_COUNT, 32'd0);
        row_smp(16'sh7FFF, 1'b1, 1'b1, 15'd0);
        // Zero buckets: the final emits nothing
        row_cfg(REG_BUCKET_COUNT, 32'd0);
        row_cfg(REG_CHANNEL_COUNT, 32'd3);
        row_cfg(REG_FRAME_COUNT, 32'd4);
        row_smp(16'sd500, 1'b0, 1'b0, '0);
        row_smp(-16'sd600, 1'b0, 1'b0, '0);
        row_smp(16'sd7, 1'b1, 1'b0, '0);
        // Oversized bucket count, zero channel count, largest frame count
        row_cfg(REG_BUCKET_COUNT, 32'd127);
        row_cfg(REG_CHANNEL_COUNT, 32'd0);
        row_cfg(REG_FRAME_COUNT, 32'h7FFF_FFFF);
        row_smp(-16'sd20000, 1'b0, 1'b0, '0);
        row_smp(16'sd300, 1'b1, 1'b0, '0);
        // Widest frame; the final drops the partial frame
        row_cfg(REG_BUCKET_COUNT, 32'd65);
        row_cfg(REG_CHANNEL_COUNT, 32'd255);
        row_cfg(REG_FRAME_COUNT, 32'd2);
        row_smp(16'sd1000, 1'b0, 1'b0, '0);
        row_smp(-16'sd2000, 1'b1, 1'b0, '0);
        // Channel count lowered mid-frame closes the frame early
        row_cfg(REG_BUCKET_COUNT, 32'd3);
        row_cfg(REG_CHANNEL_COUNT, 32'd4);
        row_cfg(REG_FRAME_COUNT, 32'd3);
        row_smp(16'sd10, 1'b0, 1'b0, '0);
        row_smp(-16'sd40, 1'b0, 1'b0, '0);
        row_cfg(REG_CHANNEL_COUNT, 32'd2);
        row_smp(16'sd5, 1'b0, 1'b0, '0);
        row_smp(16'sd8000, 1'b0, 1'b0, '0);
        row_smp(16'sd1, 1'b0, 1'b0, '0);
        row_smp(16'sd2, 1'b0, 1'b0, '0);
        row_smp(-16'sd3, 1'b1, 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        gap_pct = 20;
        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.is_cfg) begin
                settle();
                cfg_write(row.reg_idx, row.value);
            end else begin
                send_sample(row.smp, row.fin, row.typed, row.typed_peak);
            end
        end

        // Random phases: new settings, then runs of whole frames closed by a final
        for (int ph = 0; n_items < ITEM_TARGET; ph++) begin
            settle();
            case ($urandom_range(9))
                0:       bc = 0;
                1:       bc = $urandom_range(65, 127);
                2, 3:    bc = MAX_BUCKETS;
                default: bc = $urandom_range(1, 63);
            endcase
            case ($urandom_range(9))
                0:       cc = 0;
                1:       cc = $urandom_range(17, 40);
                default: cc = $urandom_range(1, 6);
            endcase
            case ($urandom_range(9))
                0:       fc = 0;
                1:       fc = 32'h7FFF_FFFF;
                2:       fc = $urandom() & 32'h7FFF_FFFF;
                3:       fc = $urandom_range(1, 3);
                default: fc = $urandom_range(4, 40);
            endcase
            // Second phase fills the block while the result side holds off
            if (ph == 1) begin
                bc = MAX_BUCKETS;
                cc = 1;
                fc = 16;
            end
            cfg_write(REG_BUCKET_COUNT, bc);
            cfg_write(REG_CHANNEL_COUNT, cc);
            cfg_write(REG_FRAME_COUNT, fc);

            case ($urandom_range(2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            if (n_items >= QUIET_FROM) gap_pct = 0;
            if (ph == 1) begin
                gap_pct  = 0;
                hold_req = 1'b1;
            end

            ce   = (cc == 0) ? 1 : int'(cc);
            runs = (ph == 1) ? 3 : $urandom_range(1, 3);
            for (int r = 0; r < runs; r++) begin
                nfr   = (ph == 1) ? 12 : $urandom_range(0, (ce > 8) ? 3 : 10);
                total = nfr * ce + (($urandom_range(3) == 0) ? $urandom_range(ce - 1) : 0);
                if (total == 0) total = 1;
                for (int k = 1; k <= total; k++) begin
                    case ($urandom_range(7))
                        0:       s = 16'sh8000;
                        1:       s = 16'sh7FFF;
                        2:       s = SAMPLE_W'($urandom_range(31)) - 16'sd16;
                        default: s = SAMPLE_W'($urandom());
                    endcase
                    // Mostly the final closes the run; now and then it breaks a run early
                    send_sample(s, (k == total) || ($urandom_range(29) == 0), 1'b0, '0);
                end
            end
        end

        settle();
        $display("tb_audio_peak_envelope_top: %0d samples, %0d finals, %0d register writes",
                 n_items, n_flushes, n_cfg);
        $display("tb_audio_peak_envelope_top: %0d bucket peaks compared, %0d input stall cycles",
                 n_results, n_in_stalls);
        if (err_count == 0) begin
            $display("tb_audio_peak_envelope_top: done, clean");
        end else begin
            $display("tb_audio_peak_envelope_top: done, errors");
        end
        $finish;
    end

endmodule
